// ===== rtl/core/fixed_corotated_stress_kernel_unit_macros.svh =====
// Assertion macros shared by the checker of the stress kernel unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FIXED_COROTATED_STRESS_KERNEL_UNIT_MACROS_SVH
`define FIXED_COROTATED_STRESS_KERNEL_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FCSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FCSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fcsk_pkg.sv =====
// Shared types, constants and the sequencer program of the stress kernel.
// No dependencies; imported by every module of the unit.
package fcsk_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int PC_W = 7;
	localparam int RF_DEPTH = 16;
	localparam int RF_AW = $clog2(RF_DEPTH);
	localparam int DIV_BITS = 88;
	localparam int DIV_CW = $clog2(DIV_BITS);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd2;

	localparam logic [24:0] FLOOR_RESET = 25'd17;
	localparam logic [63:0] ONE_Q24 = 64'd16777216;
	localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SAT_MIN = {1'b1, 63'd0};

	localparam logic [PC_W-1:0] M0_START = 7'd5;
	localparam logic [PC_W-1:0] M1_START = 7'd30;

	// operand selectors: below 16 a scratch register, 16 and above a fixed source
	localparam logic [4:0] SF0 = 5'd16;
	localparam logic [4:0] SF1 = 5'd17;
	localparam logic [4:0] SF2 = 5'd18;
	localparam logic [4:0] SSCALE = 5'd19;
	localparam logic [4:0] SMU = 5'd20;
	localparam logic [4:0] SLA = 5'd21;
	localparam logic [4:0] SMU2 = 5'd22;
	localparam logic [4:0] SLAH = 5'd23;
	localparam logic [4:0] SONE = 5'd24;

	typedef struct packed {
		logic        mode;
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] s3;
		logic [30:0] scale;
	} item_t;

	typedef enum logic [2:0] {OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_CLAMP} op_t;

	typedef struct packed {
		op_t              op;
		logic [RF_AW-1:0] dst;
		logic [4:0]       src_a;
		logic [4:0]       src_b;
		logic             emit;
		logic             last;
		logic             branch;
	} inst_t;

	function automatic inst_t mk(input op_t op, input logic [3:0] dst, input logic [4:0] a,
			input logic [4:0] b, input logic emit, input logic last, input logic branch);
		inst_t i;
		i.op = op;
		i.dst = dst;
		i.src_a = a;
		i.src_b = b;
		i.emit = emit;
		i.last = last;
		i.branch = branch;
		return i;
	endfunction

	// Program: shared prologue, then mode 0 from M0_START, mode 1 from M1_START.
	// Scratch: 0-2 cofactors, 3 J, 4 J-1, 15 discard for emitted values.
	function automatic inst_t prog(input logic [PC_W-1:0] pc);
		inst_t p;
		unique case (pc)
			7'd0:  p = mk(OP_MUL, 4'd0, SF1, SF2, 1'b0, 1'b0, 1'b0);
			7'd1:  p = mk(OP_MUL, 4'd1, SF0, SF2, 1'b0, 1'b0, 1'b0);
			7'd2:  p = mk(OP_MUL, 4'd2, SF0, SF1, 1'b0, 1'b0, 1'b0);
			7'd3:  p = mk(OP_MUL, 4'd3, 5'd2, SF2, 1'b0, 1'b0, 1'b0);
			7'd4:  p = mk(OP_SUB, 4'd4, 5'd3, SONE, 1'b0, 1'b0, 1'b1);
			// stress and energy
			7'd5:  p = mk(OP_MUL, 4'd5, SSCALE, SMU, 1'b0, 1'b0, 1'b0);
			7'd6:  p = mk(OP_ADD, 4'd5, 5'd5, 5'd5, 1'b0, 1'b0, 1'b0);
			7'd7:  p = mk(OP_MUL, 4'd6, SSCALE, SLA, 1'b0, 1'b0, 1'b0);
			7'd8:  p = mk(OP_MUL, 4'd6, 5'd6, 5'd4, 1'b0, 1'b0, 1'b0);
			7'd9:  p = mk(OP_SUB, 4'd7, SF0, SONE, 1'b0, 1'b0, 1'b0);
			7'd10: p = mk(OP_SUB, 4'd8, SF1, SONE, 1'b0, 1'b0, 1'b0);
			7'd11: p = mk(OP_SUB, 4'd9, SF2, SONE, 1'b0, 1'b0, 1'b0);
			7'd12: p = mk(OP_MUL, 4'd10, 5'd5, 5'd7, 1'b0, 1'b0, 1'b0);
			7'd13: p = mk(OP_MUL, 4'd11, 5'd6, 5'd0, 1'b0, 1'b0, 1'b0);
			7'd14: p = mk(OP_ADD, 4'd15, 5'd10, 5'd11, 1'b1, 1'b0, 1'b0);
			7'd15: p = mk(OP_MUL, 4'd10, 5'd5, 5'd8, 1'b0, 1'b0, 1'b0);
			7'd16: p = mk(OP_MUL, 4'd11, 5'd6, 5'd1, 1'b0, 1'b0, 1'b0);
			7'd17: p = mk(OP_ADD, 4'd15, 5'd10, 5'd11, 1'b1, 1'b0, 1'b0);
			7'd18: p = mk(OP_MUL, 4'd10, 5'd5, 5'd9, 1'b0, 1'b0, 1'b0);
			7'd19: p = mk(OP_MUL, 4'd11, 5'd6, 5'd2, 1'b0, 1'b0, 1'b0);
			7'd20: p = mk(OP_ADD, 4'd15, 5'd10, 5'd11, 1'b1, 1'b0, 1'b0);
			7'd21: p = mk(OP_MUL, 4'd13, 5'd7, 5'd7, 1'b0, 1'b0, 1'b0);
			7'd22: p = mk(OP_MUL, 4'd12, 5'd8, 5'd8, 1'b0, 1'b0, 1'b0);
			7'd23: p = mk(OP_ADD, 4'd13, 5'd13, 5'd12, 1'b0, 1'b0, 1'b0);
			7'd24: p = mk(OP_MUL, 4'd12, 5'd9, 5'd9, 1'b0, 1'b0, 1'b0);
			7'd25: p = mk(OP_ADD, 4'd13, 5'd13, 5'd12, 1'b0, 1'b0, 1'b0);
			7'd26: p = mk(OP_MUL, 4'd10, SMU, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd27: p = mk(OP_MUL, 4'd11, 5'd4, 5'd4, 1'b0, 1'b0, 1'b0);
			7'd28: p = mk(OP_MUL, 4'd11, SLAH, 5'd11, 1'b0, 1'b0, 1'b0);
			7'd29: p = mk(OP_ADD, 4'd15, 5'd10, 5'd11, 1'b1, 1'b1, 1'b0);
			// derivative terms
			7'd30: p = mk(OP_ADD, 4'd5, 5'd3, 5'd3, 1'b0, 1'b0, 1'b0);
			7'd31: p = mk(OP_SUB, 4'd5, 5'd5, SONE, 1'b0, 1'b0, 1'b0);
			7'd32: p = mk(OP_SUB, 4'd6, SONE, 5'd3, 1'b0, 1'b0, 1'b0);
			7'd33: p = mk(OP_CLAMP, 4'd7, SF0, SF1, 1'b0, 1'b0, 1'b0);
			7'd34: p = mk(OP_CLAMP, 4'd8, SF0, SF2, 1'b0, 1'b0, 1'b0);
			7'd35: p = mk(OP_CLAMP, 4'd9, SF1, SF2, 1'b0, 1'b0, 1'b0);
			7'd36: p = mk(OP_MUL, 4'd10, SLA, SF2, 1'b0, 1'b0, 1'b0);
			7'd37: p = mk(OP_MUL, 4'd11, SLA, SF1, 1'b0, 1'b0, 1'b0);
			7'd38: p = mk(OP_MUL, 4'd12, SLA, SF0, 1'b0, 1'b0, 1'b0);
			7'd39: p = mk(OP_MUL, 4'd13, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0);
			7'd40: p = mk(OP_MUL, 4'd13, SLA, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd41: p = mk(OP_ADD, 4'd15, SMU2, 5'd13, 1'b1, 1'b0, 1'b0);
			7'd42: p = mk(OP_MUL, 4'd13, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0);
			7'd43: p = mk(OP_MUL, 4'd13, SLA, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd44: p = mk(OP_ADD, 4'd15, SMU2, 5'd13, 1'b1, 1'b0, 1'b0);
			7'd45: p = mk(OP_MUL, 4'd13, 5'd2, 5'd2, 1'b0, 1'b0, 1'b0);
			7'd46: p = mk(OP_MUL, 4'd13, SLA, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd47: p = mk(OP_ADD, 4'd15, SMU2, 5'd13, 1'b1, 1'b0, 1'b0);
			7'd48: p = mk(OP_MUL, 4'd15, 5'd10, 5'd5, 1'b1, 1'b0, 1'b0);
			7'd49: p = mk(OP_MUL, 4'd15, 5'd11, 5'd5, 1'b1, 1'b0, 1'b0);
			7'd50: p = mk(OP_MUL, 4'd15, 5'd12, 5'd5, 1'b1, 1'b0, 1'b0);
			7'd51: p = mk(OP_DIV, 4'd13, SMU2, 5'd7, 1'b0, 1'b0, 1'b0);
			7'd52: p = mk(OP_MUL, 4'd14, 5'd10, 5'd6, 1'b0, 1'b0, 1'b0);
			7'd53: p = mk(OP_ADD, 4'd15, 5'd13, 5'd14, 1'b1, 1'b0, 1'b0);
			7'd54: p = mk(OP_DIV, 4'd13, SMU2, 5'd8, 1'b0, 1'b0, 1'b0);
			7'd55: p = mk(OP_MUL, 4'd14, 5'd11, 5'd6, 1'b0, 1'b0, 1'b0);
			7'd56: p = mk(OP_ADD, 4'd15, 5'd13, 5'd14, 1'b1, 1'b0, 1'b0);
			7'd57: p = mk(OP_DIV, 4'd13, SMU2, 5'd9, 1'b0, 1'b0, 1'b0);
			7'd58: p = mk(OP_MUL, 4'd14, 5'd12, 5'd6, 1'b0, 1'b0, 1'b0);
			7'd59: p = mk(OP_ADD, 4'd15, 5'd13, 5'd14, 1'b1, 1'b0, 1'b0);
			7'd60: p = mk(OP_DIV, 4'd13, SONE, 5'd7, 1'b0, 1'b0, 1'b0);
			7'd61: p = mk(OP_SUB, 4'd13, SONE, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd62: p = mk(OP_MUL, 4'd15, SMU2, 5'd13, 1'b1, 1'b0, 1'b0);
			7'd63: p = mk(OP_DIV, 4'd13, SONE, 5'd8, 1'b0, 1'b0, 1'b0);
			7'd64: p = mk(OP_SUB, 4'd13, SONE, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd65: p = mk(OP_MUL, 4'd15, SMU2, 5'd13, 1'b1, 1'b0, 1'b0);
			7'd66: p = mk(OP_DIV, 4'd13, SONE, 5'd9, 1'b0, 1'b0, 1'b0);
			7'd67: p = mk(OP_SUB, 4'd13, SONE, 5'd13, 1'b0, 1'b0, 1'b0);
			7'd68: p = mk(OP_MUL, 4'd15, SMU2, 5'd13, 1'b1, 1'b1, 1'b0);
			default: p = mk(OP_ADD, 4'd15, SONE, SONE, 1'b0, 1'b1, 1'b0);
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/fixed_corotated_stress_kernel_unit.sv =====
// Each item runs the shared prologue and its mode's program; the run time is set by
// the shared multiplier (four 32x32 quarters per product step), the radix-2 divider
// (six quotient steps in mode 1) and the ALU steps.
// The sequencer takes a new item only once the last is through; a two-entry input
// queue and the output register let both sides stall independently.
// Reset (arst_n low, async): queue emptied, sequencer idle, no result valid,
// registers back to mu 0, lambda 0, divisor floor 17.
module fixed_corotated_stress_kernel_unit import fcsk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [127:0]          s_axis_tdata,  // sigma_one, sigma_two, sigma_three, stress_scale
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [63:0]           m_axis_tdata,  // value
	output logic [3:0]            m_axis_tuser,  // term
	output logic                  m_axis_tlast
);

	logic  q_valid, q_pop;
	item_t q_item;

	fcsk_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	fcsk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/core/fcsk_front.sv =====
// Front end: accepts input transfers and buffers them in a two-entry queue.
// Depends on fcsk_pkg.
module fcsk_front import fcsk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // sigma_one, sigma_two, sigma_three, stress_scale, pad
	input  logic         s_axis_tuser,  // mode
	output logic         q_valid,
	output item_t        q_item,
	input  logic         q_pop
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	item_t             in_item;

	// unpack the transfer into an item
	always_comb begin
		in_item.mode = s_axis_tuser;
		in_item.s1 = s_axis_tdata[31:0];
		in_item.s2 = s_axis_tdata[63:32];
		in_item.s3 = s_axis_tdata[95:64];
		in_item.scale = s_axis_tdata[126:96];
	end

	assign s_axis_tready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push = s_axis_tvalid && s_axis_tready;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/fcsk_mul.sv =====
// Q40.24 multiplier: 64x64 magnitude product from four 32x32 partial
// products, one per cycle, then floor rounding and saturation. Uses fcsk_pkg.
module fcsk_mul import fcsk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	logic [63:0]  res_q;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [103:0] q;
	logic [63:0]  settled;

	// partial product for the current quarter
	always_comb begin
		pp = (cnt_q[1] ? ua_q[63:32] : ua_q[31:0]) * (cnt_q[0] ? ub_q[63:32] : ub_q[31:0]);
		case (cnt_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// shift by 24, round toward minus infinity, saturate
	always_comb begin
		q = acc_q[127:24] + {103'd0, neg_q && (acc_q[23:0] != '0)};
		if (neg_q) begin
			settled = (q > {40'd0, SAT_MIN}) ? SAT_MIN : (~q[63:0] + 64'd1);
		end else begin
			settled = (q[103:63] != '0) ? SAT_MAX : q[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				ua_q <= a[63] ? (~a + 64'd1) : a;
				ub_q <= b[63] ? (~b + 64'd1) : b;
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + pp_sh;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) res_q <= settled;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/core/fcsk_div.sv =====
// Q40.24 divider: restoring radix-2, one quotient bit per cycle over the
// 88-bit scaled numerator, truncating toward zero, saturating. Uses fcsk_pkg.
module fcsk_div import fcsk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] res
);

	logic [DIV_BITS-1:0] num_q;
	logic [63:0]         ud_q, r_q, q_q, res_q;
	logic                ovf_q, neg_q, busy_q, fin_q, done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [64:0]         r_n;
	logic                ge;
	logic [63:0]         ua, ud, settled;

	assign ua = a[63] ? (~a + 64'd1) : a;
	assign ud = d[63] ? (~d + 64'd1) : d;

	// one restoring step
	assign r_n = {r_q, num_q[DIV_BITS-1]};
	assign ge = (r_n >= {1'b0, ud_q});

	always_comb begin
		if (neg_q) begin
			settled = (ovf_q || (q_q > SAT_MIN)) ? SAT_MIN : (~q_q + 64'd1);
		end else begin
			settled = (ovf_q || q_q[63]) ? SAT_MAX : q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				num_q <= {ua, 24'd0};
				ud_q <= (ud == '0) ? 64'd1 : ud;
				neg_q <= a[63] ^ d[63];
				r_q <= '0;
				q_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q <= ge ? 64'(r_n - {1'b0, ud_q}) : r_n[63:0];
				q_q <= {q_q[62:0], ge};
				ovf_q <= ovf_q | q_q[63];
				num_q <= {num_q[DIV_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) res_q <= settled;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/core/fcsk_back.sv =====
// Back end: configuration registers, program sequencer, scratch registers,
// ALU and output register. Uses fcsk_pkg, fcsk_mul and fcsk_div.
module fcsk_back import fcsk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [63:0]           m_axis_tdata,
	output logic [3:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_WB} state_t;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	item_t           item_q;
	logic [3:0]      term_q;
	logic [63:0]     a_q, b_q, res_q;
	logic [63:0]     rf [RF_DEPTH];
	logic [39:0]     mu_q, lam_q;
	logic [24:0]     floor_q;
	logic            out_valid_q, out_last_q;
	logic [63:0]     out_data_q;
	logic [3:0]      out_term_q;

	inst_t       inst;
	logic        mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_res, div_res;
	logic [63:0] sum, diff, alu_res, fl, neg_sum;
	logic        out_free, wb_fire, rf_we;

	assign inst = prog(pc_q);

	// fixed operand sources
	function automatic logic [63:0] spec(input logic [4:0] sel, input item_t it,
			input logic [39:0] mu, input logic [39:0] lam);
		logic [63:0] v;
		case (sel)
			SF0:     v = {{32{it.s1[31]}}, it.s1};
			SF1:     v = {{32{it.s2[31]}}, it.s2};
			SF2:     v = {{32{it.s3[31]}}, it.s3};
			SSCALE:  v = {33'd0, it.scale};
			SMU:     v = {16'd0, mu, 8'd0};
			SLA:     v = {{16{lam[39]}}, lam, 8'd0};
			SMU2:    v = {15'd0, mu, 9'd0};
			SLAH:    v = {{17{lam[39]}}, lam, 7'd0};
			SONE:    v = ONE_Q24;
			default: v = '0;
		endcase
		return v;
	endfunction

	// saturating add and subtract, divisor clamp
	always_comb begin
		sum = a_q + b_q;
		diff = a_q - b_q;
		fl = {39'd0, (floor_q == '0) ? 25'd1 : floor_q};
		neg_sum = ~sum + 64'd1;
		case (inst.op)
			OP_ADD: begin
				if ((a_q[63] == b_q[63]) && (sum[63] != a_q[63]))
					alu_res = a_q[63] ? SAT_MIN : SAT_MAX;
				else
					alu_res = sum;
			end
			OP_SUB: begin
				if ((a_q[63] != b_q[63]) && (diff[63] != a_q[63]))
					alu_res = a_q[63] ? SAT_MIN : SAT_MAX;
				else
					alu_res = diff;
			end
			OP_CLAMP: begin
				if (sum[63])
					alu_res = (neg_sum < fl) ? (~fl + 64'd1) : sum;
				else
					alu_res = (sum < fl) ? fl : sum;
			end
			default: alu_res = sum;
		endcase
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign wb_fire = (state_q == ST_WB) && (!inst.emit || out_free);
	assign rf_we = wb_fire;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign mul_start = (state_q == ST_EXEC) && (inst.op == OP_MUL);
	assign div_start = (state_q == ST_EXEC) && (inst.op == OP_DIV);

	fcsk_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (a_q),
		.b      (b_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	fcsk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (a_q),
		.d      (b_q),
		.done   (div_done),
		.res    (div_res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= '0;
			lam_q <= '0;
			floor_q <= FLOOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHEAR:  mu_q <= cfg_data;
				REG_LAMBDA: lam_q <= cfg_data;
				REG_FLOOR:  floor_q <= cfg_data[24:0];
				default:    ;
			endcase
		end
	end

	// scratch register file
	always_ff @(posedge clk) begin
		if (rf_we) rf[inst.dst] <= res_q;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			term_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						pc_q <= '0;
						term_q <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					a_q <= inst.src_a[4] ? spec(inst.src_a, item_q, mu_q, lam_q)
						: rf[inst.src_a[RF_AW-1:0]];
					b_q <= inst.src_b[4] ? spec(inst.src_b, item_q, mu_q, lam_q)
						: rf[inst.src_b[RF_AW-1:0]];
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (inst.op == OP_MUL || inst.op == OP_DIV) begin
						state_q <= ST_WAIT;
					end else begin
						res_q <= alu_res;
						state_q <= ST_WB;
					end
				end
				ST_WAIT: begin
					if (inst.op == OP_MUL && mul_done) begin
						res_q <= mul_res;
						state_q <= ST_WB;
					end else if (inst.op == OP_DIV && div_done) begin
						res_q <= div_res;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_fire) begin
						if (inst.emit) begin
							out_valid_q <= 1'b1;
							out_data_q <= res_q;
							out_term_q <= term_q;
							out_last_q <= inst.last;
							term_q <= term_q + 4'd1;
						end
						if (inst.last) begin
							state_q <= ST_IDLE;
						end else begin
							if (inst.branch)
								pc_q <= item_q.mode ? M1_START : M0_START;
							else
								pc_q <= pc_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_term_q;
	assign m_axis_tlast = out_last_q;

endmodule

// ===== rtl/core/fcsk_checker.sv =====
// Port-level checker for the stress kernel unit, bound to the top level.
// Depends on fixed_corotated_stress_kernel_unit_macros.svh.
`include "fixed_corotated_stress_kernel_unit_macros.svh"

module fcsk_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [1:0]   cfg_index,
	input logic [39:0]  cfg_data,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [127:0] s_axis_tdata,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a stalled result holds
	`FCSK_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	// term index stays within the derivative set
	`FCSK_ASSERT_NOW(a_term_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= 4'd11, "term index out of range")
	// a run ends only on the energy or the last derivative term
	`FCSK_ASSERT_NOW(a_last_term, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 4'd3 || m_axis_tuser == 4'd11, "last on wrong term")
	// the final derivative term always closes its run
	`FCSK_ASSERT_NOW(a_term11_last, clk, arst_n, m_axis_tvalid && m_axis_tuser == 4'd11, m_axis_tlast, "term 11 without last")

endmodule

bind fixed_corotated_stress_kernel_unit fcsk_checker u_fcsk_checker (.*);
